// ----- sv/pcfm_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfm_pkg
// Shared types, constants and tables of the channel frequency meter.
// ----------------------------------------------------------------------------
package pcfm_pkg;

  // Field widths
  localparam int unsigned LEVEL_W   = 5;
  localparam int unsigned DMA_W     = 16;
  localparam int unsigned VOICE_W   = 2;
  localparam int unsigned VOLUME_W  = 8;
  localparam int unsigned NOTE_W    = 18;
  localparam int unsigned SCOPE_W   = 8;
  localparam int unsigned MUTE_W    = 4;
  localparam int unsigned STEP_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned INDEX_W   = 64;
  localparam int unsigned NUM_TONES = 3;

  // Rates
  localparam int unsigned RATE_DEFAULT = 250332;
  localparam int unsigned OUT_RATE     = 44100;
  localparam int unsigned PERIOD_LIMIT = 250332;
  localparam int unsigned DECIM_FRAC_BITS_DEFAULT = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

  // Voice codes
  localparam logic [VOICE_W-1:0] VOICE_A   = 2'd0;
  localparam logic [VOICE_W-1:0] VOICE_B   = 2'd1;
  localparam logic [VOICE_W-1:0] VOICE_C   = 2'd2;
  localparam logic [VOICE_W-1:0] VOICE_DMA = 2'd3;

  // Scope centering offset for tone levels
  localparam logic [SCOPE_W-1:0] SCOPE_CENTER = 8'd124;

  // level * 255 / 31, truncated
  localparam logic [VOLUME_W-1:0] VOL_TABLE [0:31] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_RANGE,
    ST_DIVIDE,
    ST_PUBLISH
  } pcfm_state_t;

  // Divider control and status
  typedef struct packed {
    logic start;
  } pcfm_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pcfm_div_stat_t;

endpackage

// ----- sv/pcfm_divider.sv -----
// ----------------------------------------------------------------------------
// pcfm_divider
// Restoring divider, one quotient bit per cycle, shared by the tone voices.
// ----------------------------------------------------------------------------
module pcfm_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  pcfm_pkg::pcfm_div_ctrl_t      ctrl,
  input  logic [pcfm_pkg::NOTE_W-1:0]   dividend,
  input  logic [pcfm_pkg::NOTE_W-1:0]   divisor,
  output pcfm_pkg::pcfm_div_stat_t      stat,
  output logic [pcfm_pkg::NOTE_W-1:0]   quotient
);
  import pcfm_pkg::*;

  localparam int unsigned CNT_W = $clog2(NOTE_W + 1);

  logic [NOTE_W:0]   rem;
  logic [NOTE_W-1:0] quo;
  logic [NOTE_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [NOTE_W:0]   shifted;
  logic [NOTE_W:0]   trial;
  logic              fits;
  logic [NOTE_W:0]   rem_next;
  logic [NOTE_W-1:0] quo_next;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted  = {rem[NOTE_W-1:0], quo[NOTE_W-1]};
    trial    = shifted - {1'b0, dsr};
    fits     = (shifted >= {1'b0, dsr});
    rem_next = fits ? trial : shifted;
    quo_next = {quo[NOTE_W-2:0], fits};
  end

  // Control: load on start, count down the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NOTE_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ----- sv/pcfm_decimator.sv -----
// ----------------------------------------------------------------------------
// pcfm_decimator
// Fixed-point rate accumulator that marks which samples feed the scope.
// ----------------------------------------------------------------------------
module pcfm_decimator #(
  parameter int unsigned DECIM_FRAC_BITS = pcfm_pkg::DECIM_FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [pcfm_pkg::STEP_W-1:0]   step,
  output logic                          scope_hit
);
  import pcfm_pkg::*;

  localparam int unsigned ACC_W = DECIM_FRAC_BITS + 5;
  localparam int unsigned CMP_W = (ACC_W > STEP_W) ? ACC_W : STEP_W;
  localparam logic [ACC_W-1:0] UNIT = ACC_W'(1) << DECIM_FRAC_BITS;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_sum;
  logic [CMP_W-1:0] sum_ext;
  logic [CMP_W-1:0] step_ext;
  logic [ACC_W-1:0] acc_next;

  // Add one unit, take out a step when the sum reaches it
  always_comb begin
    acc_sum   = acc + UNIT;
    sum_ext   = CMP_W'(acc_sum);
    step_ext  = CMP_W'(step);
    scope_hit = (sum_ext >= step_ext);
    acc_next  = scope_hit ? ACC_W'(sum_ext - step_ext) : acc_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (advance) begin
      acc <= acc_next;
    end
  end

endmodule

// ----- sv/psg_channel_frequency_meter_core.sv -----
// ----------------------------------------------------------------------------
// psg_channel_frequency_meter_core
// Per-voice meter: mute, edge timing with note in Hz, volume and scope mark.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one word per sound sample with three
//   tone levels and a stereo DMA sample. The block raises in_stall while it
//   works on a sample.
//   Output channel (out_valid / out_stall): four words per sample, voices
//   A, B, C, then DMA; last marks the DMA word.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while no sample is in flight.
// Sequence
//   Each voice gets an edge step; a voice that shows a timed rising edge
//   also gets a range check and, when its period is in range, a note
//   division in the shared 18-bit divider. The first word appears once
//   the sample is published to the result buffer.
// Stalls
//   The four words sit in a result buffer; the next sample may be taken and
//   processed while they drain, and it waits for the buffer only at the end.
// Reset
//   Clears edge history, sample counter, notes, decimation accumulator and
//   restores the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module psg_channel_frequency_meter_core #(
  parameter int unsigned DECIM_FRAC_BITS = pcfm_pkg::DECIM_FRAC_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pcfm_pkg::LEVEL_W-1:0]      level_a,
  input  logic [pcfm_pkg::LEVEL_W-1:0]      level_b,
  input  logic [pcfm_pkg::LEVEL_W-1:0]      level_c,
  input  logic signed [pcfm_pkg::DMA_W-1:0] dma_left,
  input  logic signed [pcfm_pkg::DMA_W-1:0] dma_right,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pcfm_pkg::VOICE_W-1:0]      voice,
  output logic signed [pcfm_pkg::DMA_W-1:0] mixed_level,
  output logic signed [pcfm_pkg::DMA_W-1:0] mixed_right,
  output logic [pcfm_pkg::VOLUME_W-1:0]     volume,
  output logic [pcfm_pkg::NOTE_W-1:0]       note_hz,
  output logic                              scope_write,
  output logic signed [pcfm_pkg::SCOPE_W-1:0] scope_value,
  output logic                              last,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcfm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pcfm_pkg::*;

  localparam logic [63:0] STEP_FULL =
    ((64'(RATE_DEFAULT) << DECIM_FRAC_BITS) + 64'(OUT_RATE / 2)) / 64'(OUT_RATE);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_FULL[STEP_W-1:0];

  // Configuration registers
  logic [MUTE_W-1:0] mute_mask;
  logic [STEP_W-1:0] decimation_step;
  logic [NOTE_W-1:0] sample_rate_hz;

  // Edge history and notes
  logic               previous_on [NUM_TONES];
  logic               edge_seen   [NUM_TONES];
  logic [INDEX_W-1:0] edge_index  [NUM_TONES];
  logic [NOTE_W-1:0]  note_store  [NUM_TONES];
  logic [INDEX_W-1:0] sample_index;
  logic [INDEX_W-1:0] period;

  // Sample being processed
  logic [LEVEL_W-1:0] item_lv [NUM_TONES];
  logic [DMA_W-1:0]   item_left;
  logic [DMA_W-1:0]   item_right;

  // Result buffer
  logic               buf_valid;
  logic [VOICE_W-1:0] rd_idx;
  logic [LEVEL_W-1:0] buf_lv   [NUM_TONES];
  logic [NOTE_W-1:0]  buf_note [NUM_TONES];
  logic [DMA_W-1:0]   buf_left;
  logic [DMA_W-1:0]   buf_right;
  logic               buf_sw;

  // Sequencer
  pcfm_state_t        state;
  pcfm_state_t        state_next;
  logic [VOICE_W-1:0] cur;
  logic               cur_on;
  logic               rising;
  logic               timed;
  logic               period_ok;
  logic               last_voice;
  logic               voice_step;
  logic               publish;

  pcfm_div_ctrl_t     div_ctrl;
  pcfm_div_stat_t     div_stat;
  logic [NOTE_W-1:0]  div_quotient;
  logic               scope_hit;

  logic               in_take;
  logic               out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // Current voice view
  always_comb begin
    cur_on     = (item_lv[cur] != '0);
    rising     = cur_on && !previous_on[cur];
    timed      = rising && edge_seen[cur];
    period_ok  = (period != '0) && (period < INDEX_W'(PERIOD_LIMIT));
    last_voice = (cur == VOICE_C);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EDGE;
      end
      ST_EDGE: begin
        if (timed) state_next = ST_RANGE;
        else if (last_voice) state_next = ST_PUBLISH;
      end
      ST_RANGE: begin
        if (period_ok) state_next = ST_DIVIDE;
        else state_next = last_voice ? ST_PUBLISH : ST_EDGE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) state_next = last_voice ? ST_PUBLISH : ST_EDGE;
      end
      ST_PUBLISH: begin
        if (!buf_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall       = 1'b1;
    div_ctrl.start = 1'b0;
    voice_step     = 1'b0;
    publish        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_EDGE: begin
        voice_step = !timed && !last_voice;
      end
      ST_RANGE: begin
        div_ctrl.start = period_ok;
        voice_step     = !period_ok && !last_voice;
      end
      ST_DIVIDE: begin
        voice_step = div_stat.done && !last_voice;
      end
      ST_PUBLISH: begin
        publish = !buf_valid;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mute_mask       <= '0;
      decimation_step <= STEP_RESET;
      sample_rate_hz  <= NOTE_W'(RATE_DEFAULT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MUTE_MASK:   mute_mask       <= cfg_data[MUTE_W-1:0];
        CFG_DECIM_STEP:  decimation_step <= cfg_data[STEP_W-1:0];
        CFG_SAMPLE_RATE: sample_rate_hz  <= cfg_data[NOTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the sample
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_lv[0] <= level_a;
      item_lv[1] <= level_b;
      item_lv[2] <= level_c;
      item_left  <= dma_left;
      item_right <= dma_right;
    end
  end

  // Voice pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= VOICE_A;
    end else if (in_take) begin
      cur <= VOICE_A;
    end else if (voice_step) begin
      cur <= cur + VOICE_W'(1);
    end
  end

  // Edge history, sample counter and notes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        previous_on[i] <= 1'b0;
        edge_seen[i]   <= 1'b0;
        edge_index[i]  <= '0;
        note_store[i]  <= '0;
      end
      sample_index <= '0;
    end else begin
      if (state == ST_EDGE) begin
        previous_on[cur] <= cur_on;
        if (rising) begin
          edge_index[cur] <= sample_index;
          edge_seen[cur]  <= 1'b1;
        end
      end
      if (state == ST_DIVIDE && div_stat.done) begin
        note_store[cur] <= div_quotient;
      end
      if (publish) begin
        sample_index <= sample_index + INDEX_W'(1);
      end
    end
  end

  // Elapsed samples since the last edge of the current voice
  always_ff @(posedge clk) begin
    if (state == ST_EDGE && timed) begin
      period <= sample_index - edge_index[cur];
    end
  end

  pcfm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (sample_rate_hz),
    .divisor  (period[NOTE_W-1:0]),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  pcfm_decimator #(
    .DECIM_FRAC_BITS (DECIM_FRAC_BITS)
  ) u_decimator (
    .clk       (clk),
    .rst       (rst),
    .advance   (publish),
    .step      (decimation_step),
    .scope_hit (scope_hit)
  );

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      rd_idx    <= VOICE_A;
    end else if (publish) begin
      buf_valid <= 1'b1;
      rd_idx    <= VOICE_A;
    end else if (out_take) begin
      if (rd_idx == VOICE_DMA) begin
        buf_valid <= 1'b0;
      end else begin
        rd_idx <= rd_idx + VOICE_W'(1);
      end
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (publish) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        buf_lv[i]   <= item_lv[i];
        buf_note[i] <= note_store[i];
      end
      buf_left  <= item_left;
      buf_right <= item_right;
      buf_sw    <= scope_hit;
    end
  end

  // Output word for the selected voice
  always_comb begin
    logic [LEVEL_W-1:0] lv;
    logic               muted;
    lv          = '0;
    muted       = mute_mask[rd_idx];
    voice       = rd_idx;
    last        = (rd_idx == VOICE_DMA);
    scope_write = buf_sw;
    mixed_right = '0;
    volume      = '0;
    note_hz     = '0;
    case (rd_idx)
      VOICE_A: begin
        lv      = buf_lv[0];
        note_hz = buf_note[0];
      end
      VOICE_B: begin
        lv      = buf_lv[1];
        note_hz = buf_note[1];
      end
      VOICE_C: begin
        lv      = buf_lv[2];
        note_hz = buf_note[2];
      end
      default: lv = '0;
    endcase
    if (rd_idx == VOICE_DMA) begin
      mixed_level = muted ? '0 : buf_left;
      mixed_right = muted ? '0 : buf_right;
      scope_value = (buf_sw && !muted) ? buf_left[DMA_W-1:DMA_W-SCOPE_W] : '0;
    end else begin
      mixed_level = muted ? '0 : DMA_W'(lv);
      volume      = VOL_TABLE[lv];
      scope_value = (buf_sw && !muted) ? ({lv, 3'b000} - SCOPE_CENTER) : '0;
    end
  end

  assign out_valid = buf_valid;

endmodule

// ----- sv/pcfm_checker.sv -----
// ----------------------------------------------------------------------------
// pcfm_checker
// Port-level checks on the frequency meter, bound to the top level.
// ----------------------------------------------------------------------------
module pcfm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [pcfm_pkg::VOICE_W-1:0]      voice,
  input logic signed [pcfm_pkg::DMA_W-1:0] mixed_level,
  input logic                              scope_write,
  input logic                              last
);
  import pcfm_pkg::*;

  // Nothing shows on the output right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // A taken sample keeps the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sample taken while previous one still in work");

  // Voices of one sample follow each other without a gap
  a_voice_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last)
      |=> (out_valid && voice == VOICE_W'($past(voice) + 2'd1)))
    else $error("voice sequence broken");

  // All four words of a sample agree on the scope mark
  a_scope_same: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (scope_write == $past(scope_write)))
    else $error("scope mark changed within one sample");

  // A stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(voice) && $stable(mixed_level)))
    else $error("stalled result word changed");

endmodule

bind psg_channel_frequency_meter_core pcfm_checker u_pcfm_checker (.*);
